[rtl/sorted_key_weight_table_unit_assert.svh]
// Assertion macros for the sorted key/weight table.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef SORTED_KEY_WEIGHT_TABLE_UNIT_ASSERT_SVH
`define SORTED_KEY_WEIGHT_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SKWT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define SKWT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SKWT_ASSERT_SAME(label, ante, cons, msg)
`define SKWT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/skwt_pkg.sv]
`default_nettype none

package skwt_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF    = 16;

    localparam int SRC_W    = 16;
    localparam int WEIGHT_W = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_SHUP,
        FSM_PLACE,
        FSM_SHDN,
        FSM_FINISH
    } fsm_t;

endpackage

`default_nettype wire

[rtl/skwt_ram.sv]
`default_nettype none

module skwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/sorted_key_weight_table_unit.sv]
// Sorted key/weight table.
// Input channel s_*: one edit item per handshake; s_tuser[0] selects insert/update (0)
// or delete (1), s_tdata carries the key and the 64-bit weight.
// Result channel m_*: one result item per edit: status, sorted slot, entry count.
// Entries live in one RAM with a registered read port; keys are kept ascending.
// An edit first walks the table from slot 0, one entry per cycle, until it reaches
// the first key not below the request. An insert of a new key then moves each later
// entry up by one slot, a delete moves each later entry down by one, again one entry
// per cycle through the RAM's read and write ports.
// An edit steps through search, then for an insert that moves entries the upward moves
// and the write of the new entry, or for a delete the downward moves, then the result
// load. One edit is worked at a time; s_tready is high while idle, in the cycle after
// the result is loaded.
// The result sits in an output register; while m_tready is low a new item is still
// taken and searched, and its result waits until the register is free.
// Reset (aresetn low, synchronous) empties the table and drops any pending result;
// RAM contents are not cleared since only data from slots below the entry count is ever used.
`default_nettype none
`include "sorted_key_weight_table_unit_assert.svh"

module sorted_key_weight_table_unit
    import skwt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // source_index[15:0], weight_bits[79:16]
    input  wire logic [0:0]          s_tuser,  // op[0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata   // status[2:0], slot[8:3], entry_count[15:9]
);

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int W1  = CW + 1;
    localparam int RW  = WEIGHT_W + KEY_BITS;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    fsm_t                state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       p_reg, p_next;
    logic [AW-1:0]       j_reg, j_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       slot_reg, slot_next;
    status_t             status_reg, status_next;
    op_t                 op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [WEIGHT_W-1:0] wgt_reg, wgt_next;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [RW-1:0]       mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [RW-1:0]       mem_rdata;

    skwt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // key from the port, zero-extended or truncated to KEY_BITS
    logic [KEY_BITS+SRC_W-1:0] src_ext;
    logic [KEY_BITS-1:0]       in_key;
    assign src_ext = {{KEY_BITS{1'b0}}, s_tdata[SRC_W-1:0]};
    assign in_key  = src_ext[KEY_BITS-1:0];

    logic                s_fire;
    logic [KEY_BITS-1:0] rd_key;
    logic                in_range, less, hit, advance, full;
    logic [CW-1:0]       p_inc, fill_dec;
    logic [W1-1:0]       p_plus1, j_plus2, fill_ext;
    logic                del_move, up_last, dn_more, out_free;

    assign s_fire   = s_tvalid && s_tready;
    assign rd_key   = mem_rdata[KEY_BITS-1:0];
    assign in_range = p_reg < fill_reg;
    assign less     = rd_key < key_reg;
    assign advance  = in_range && less;
    assign hit      = in_range && !less && (rd_key == key_reg);
    assign full     = fill_reg == MAX_CNT;
    assign p_inc    = p_reg + CW'(1);
    assign fill_dec = fill_reg - CW'(1);
    assign fill_ext = {1'b0, fill_reg};
    assign p_plus1  = {1'b0, p_reg} + W1'(1);
    assign j_plus2  = W1'(j_reg) + W1'(2);
    assign del_move = p_plus1 < fill_ext;
    assign up_last  = (j_reg - AW'(1)) == pos_reg;
    assign dn_more  = j_plus2 < fill_ext;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg        <= p_next;
        j_reg        <= j_next;
        pos_reg      <= pos_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        wgt_reg      <= wgt_next;
        out_data_reg <= out_data_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    state_next = FSM_SEARCH;
                end
            end
            FSM_SEARCH: begin
                priority if (advance) begin
                    state_next = FSM_SEARCH;
                end else if (op_reg == OP_INSERT) begin
                    if (!hit && !full && in_range) begin
                        state_next = FSM_SHUP;
                    end else begin
                        state_next = FSM_FINISH;
                    end
                end else begin
                    if (hit && del_move) begin
                        state_next = FSM_SHDN;
                    end else begin
                        state_next = FSM_FINISH;
                    end
                end
            end
            FSM_SHUP: begin
                if (up_last) begin
                    state_next = FSM_PLACE;
                end
            end
            FSM_PLACE: begin
                state_next = FSM_FINISH;
            end
            FSM_SHDN: begin
                if (!dn_more) begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_FINISH: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // datapath and memory control
    logic [AW+SLOT_W-1:0]  slot_ext;
    logic [CW+COUNT_W-1:0] count_ext;
    assign slot_ext  = {{SLOT_W{1'b0}}, slot_reg};
    assign count_ext = {{COUNT_W{1'b0}}, fill_reg};

    always_comb begin
        fill_next      = fill_reg;
        p_next         = p_reg;
        j_next         = j_reg;
        pos_next       = pos_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        wgt_next       = wgt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_waddr      = j_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = '0;
        s_tready       = 1'b0;

        unique case (state_reg)
            FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next  = op_t'(s_tuser[0]);
                    key_next = in_key;
                    wgt_next = s_tdata[SRC_W +: WEIGHT_W];
                    p_next   = '0;
                end
            end
            FSM_SEARCH: begin
                pos_next = p_reg[AW-1:0];
                priority if (advance) begin
                    p_next    = p_inc;
                    mem_raddr = p_inc[AW-1:0];
                end else if (op_reg == OP_INSERT) begin
                    priority if (hit) begin
                        mem_we      = 1'b1;
                        mem_waddr   = p_reg[AW-1:0];
                        mem_wdata   = {wgt_reg, key_reg};
                        status_next = ST_UPDATED;
                        slot_next   = p_reg[AW-1:0];
                    end else if (full) begin
                        status_next = ST_FULL;
                        slot_next   = '0;
                    end else if (!in_range) begin
                        // new key goes past the last entry
                        mem_we      = 1'b1;
                        mem_waddr   = p_reg[AW-1:0];
                        mem_wdata   = {wgt_reg, key_reg};
                        fill_next   = fill_reg + CW'(1);
                        status_next = ST_INSERTED;
                        slot_next   = p_reg[AW-1:0];
                    end else begin
                        mem_raddr   = fill_dec[AW-1:0];
                        j_next      = fill_reg[AW-1:0];
                        status_next = ST_INSERTED;
                        slot_next   = p_reg[AW-1:0];
                    end
                end else begin
                    priority if (!hit) begin
                        status_next = ST_NOT_FOUND;
                        slot_next   = '0;
                    end else if (del_move) begin
                        mem_raddr   = p_plus1[AW-1:0];
                        j_next      = p_reg[AW-1:0];
                        status_next = ST_REMOVED;
                        slot_next   = p_reg[AW-1:0];
                    end else begin
                        fill_next   = fill_dec;
                        status_next = ST_REMOVED;
                        slot_next   = p_reg[AW-1:0];
                    end
                end
            end
            FSM_SHUP: begin
                // entry j-1 was read last cycle, move it to j
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = mem_rdata;
                if (!up_last) begin
                    mem_raddr = j_reg - AW'(2);
                    j_next    = j_reg - AW'(1);
                end
            end
            FSM_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = {wgt_reg, key_reg};
                fill_next = fill_reg + CW'(1);
            end
            FSM_SHDN: begin
                // entry j+1 was read last cycle, move it to j
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = mem_rdata;
                if (dn_more) begin
                    mem_raddr = j_plus2[AW-1:0];
                    j_next    = j_reg + AW'(1);
                end else begin
                    fill_next = fill_dec;
                end
            end
            FSM_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {count_ext[COUNT_W-1:0], slot_ext[SLOT_W-1:0],
                                      status_reg};
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SKWT_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= MAX_CNT, "entry count above capacity")
    `SKWT_ASSERT_SAME(a_no_idle_write, state_reg == FSM_IDLE || state_reg == FSM_FINISH, !mem_we, "table written outside an edit")
    `SKWT_ASSERT_SAME(a_shup_order, state_reg == FSM_SHUP, j_reg > pos_reg, "upward move below insert slot")
    `SKWT_ASSERT_SAME(a_shdn_range, state_reg == FSM_SHDN, p_plus1 <= fill_ext && j_plus2 <= fill_ext + W1'(1), "downward move past last entry")
    `SKWT_ASSERT_NEXT(a_place_count, state_reg == FSM_PLACE, fill_reg == $past(fill_reg) + CW'(1), "insert did not grow the table")

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import skwt_pkg::*;

    // Result item as it sits in m_tdata, lowest field last
    typedef struct packed {
        logic [COUNT_W-1:0]  entry_count;
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } edit_result_t;

    class edit_scoreboard;
        logic [SRC_W-1:0]    keys[MAX_ENTRIES_DEF];
        logic [WEIGHT_W-1:0] weights[MAX_ENTRIES_DEF];
        int unsigned         fill;
        edit_result_t        pending_results[$];
        int                  errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // Apply one accepted edit to the shadow table and queue its result
        function void note_edit(op_t op, logic [SRC_W-1:0] src, logic [WEIGHT_W-1:0] w);
            logic [SRC_W-1:0] key;
            int unsigned      pos;
            bit               hit;
            edit_result_t     res;
            key = SRC_W'(src & ((1 << KEY_BITS_DEF) - 1));
            pos = 0;
            while (pos < fill && keys[pos] < key)
                pos++;
            hit = (pos < fill) && (keys[pos] == key);
            res.slot = '0;
            if (op == OP_INSERT) begin
                if (hit) begin
                    weights[pos] = w;
                    res.status = ST_UPDATED;
                    res.slot = pos[SLOT_W-1:0];
                end else if (fill >= MAX_ENTRIES_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    for (int unsigned j = fill; j > pos; j--) begin
                        keys[j]    = keys[j-1];
                        weights[j] = weights[j-1];
                    end
                    keys[pos]    = key;
                    weights[pos] = w;
                    fill++;
                    res.status = ST_INSERTED;
                    res.slot = pos[SLOT_W-1:0];
                end
            end else begin
                if (!hit) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    for (int unsigned j = pos; j + 1 < fill; j++) begin
                        keys[j]    = keys[j+1];
                        weights[j] = weights[j+1];
                    end
                    fill--;
                    res.status = ST_REMOVED;
                    res.slot = pos[SLOT_W-1:0];
                end
            end
            res.entry_count = fill[COUNT_W-1:0];
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            edit_result_t got;
            edit_result_t exp;
            got = edit_result_t'(data);
            if (pending_results.size() == 0) begin
                $error("result item with no edit pending: %h", data);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.slot !== exp.slot) begin
                $error("slot: expected %0d, got %0d", exp.slot, got.slot);
                errors++;
            end
            if (got.entry_count !== exp.entry_count) begin
                $error("entry_count: expected %0d, got %0d", exp.entry_count,
                       got.entry_count);
                errors++;
            end
        endfunction

        function logic [SRC_W-1:0] pick_held_key();
            return keys[$urandom_range(fill - 1)];
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    edit_scoreboard sb;
    bit             sender_quiet;
    int             results_taken;

    sorted_key_weight_table_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_edit(op_t'(s_tuser[0]), s_tdata[SRC_W-1:0],
                             s_tdata[SRC_W +: WEIGHT_W]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_edit(op_t op, logic [SRC_W-1:0] key, logic [WEIGHT_W-1:0] w);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {w, key};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly well-formed edits: deletes and updates aim at keys that are held
    task automatic random_edit(int insert_pct);
        op_t                 op;
        logic [SRC_W-1:0]    key;
        logic [WEIGHT_W-1:0] w;
        w  = {$urandom, $urandom};
        op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
        if (sb.fill > 0 && $urandom_range(99) < (op == OP_DELETE ? 80 : 20))
            key = sb.pick_held_key();
        else
            key = SRC_W'($urandom);
        send_edit(op, key, w);
    endtask

    // Result side: random stalls, stretches without stalls, one long hold-off to back the block up
    initial begin
        int  stall;
        bit  held_long;
        held_long     = 0;
        results_taken = 0;
        m_tready      = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (!held_long && results_taken == 120) begin
                stall = 600;
                held_long = 1;
            end else if ((results_taken / 40) % 3 == 2) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 10);
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
            results_taken++;
            @(negedge aclk);
        end
    end

    initial begin
        int insert_bias[6];
        insert_bias  = '{90, 50, 10, 90, 60, 20};
        sb           = new();
        sender_quiet = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty table, single entry, ends of the key range, updates
        send_edit(OP_DELETE, 16'h1234, 64'h0);
        send_edit(OP_INSERT, 16'h8000, '1);
        send_edit(OP_DELETE, 16'h8000, 64'h0);
        send_edit(OP_INSERT, 16'h0000, 64'h0);
        send_edit(OP_INSERT, 16'hFFFF, '1);
        send_edit(OP_INSERT, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_edit(OP_INSERT, 16'hAAAA, 64'h5555_5555_5555_5555);
        send_edit(OP_INSERT, 16'h0000, {$urandom, $urandom});
        send_edit(OP_INSERT, 16'hFFFF, 64'h0);
        send_edit(OP_DELETE, 16'h5555, '1);
        send_edit(OP_DELETE, 16'h1111, 64'h0);
        send_edit(OP_DELETE, 16'hFFFF, 64'h0);
        send_edit(OP_DELETE, 16'h0000, 64'h0);
        send_edit(OP_DELETE, 16'hAAAA, 64'h0);
        send_edit(OP_DELETE, 16'hAAAA, 64'h0);

        // random: grow the table, churn, drain, repeat
        for (int i = 0; i < 480; i++) begin
            sender_quiet = ((i / 50) % 3 == 1);
            random_edit(insert_bias[i / 80]);
        end
        s_tvalid = 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge aclk);
        repeat (MAX_ENTRIES_DEF + 8) @(posedge aclk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[sorted_key_weight_table_unit.f]
+incdir+rtl
rtl/skwt_pkg.sv
rtl/skwt_ram.sv
rtl/sorted_key_weight_table_unit.sv
dv/tb.sv
